/* sv/fwk_pkg.sv */
`default_nettype none

package fwk_pkg;

	localparam int ROW_W = 11;
	localparam int COL_W = 12;
	localparam int VAL_W = 15;

	typedef logic [ROW_W-1:0] row_t;
	typedef logic [COL_W-1:0] col_t;
	typedef logic [VAL_W-1:0] val_t;
	typedef logic [VAL_W:0]   wide_t;

	localparam val_t MOD_RESET = val_t'(30103);
	localparam val_t MOD_MIN   = val_t'(2);

	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

endpackage

`default_nettype wire

/* sv/fwk_mod.sv */
`default_nettype none

module fwk_mod (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  fwk_pkg::wide_t  x,
	input  fwk_pkg::val_t   m,
	output logic            done,
	output fwk_pkg::val_t   rem
);
	import fwk_pkg::*;

	localparam int STEPS = VAL_W + 1;
	localparam int CNT_W = $clog2(STEPS);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	wide_t            x_q;
	val_t             rem_q;
	wide_t            trial;

	assign trial = {rem_q, x_q[VAL_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			rem_q <= '0;
		end else if (run_q) begin
			x_q   <= x_q << 1;
			rem_q <= (trial >= {1'b0, m}) ? val_t'(trial - {1'b0, m}) : val_t'(trial);
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

/* sv/fwk_mem.sv */
`default_nettype none

module fwk_mem #(
	parameter int DEPTH = 2097152,
	parameter int AW    = 21
) (
	input  wire            clk,
	input  wire            rd_en,
	input  wire [AW-1:0]   rd_addr,
	output fwk_pkg::val_t  rd_data,
	input  wire            wr_en,
	input  wire [AW-1:0]   wr_addr,
	input  fwk_pkg::val_t  wr_data
);
	import fwk_pkg::*;

	val_t mem [DEPTH];
	val_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

/* sv/fwk_ctrl.sv */
`default_nettype none

module fwk_ctrl #(
	parameter int ROWS  = 1024,
	parameter int COLS  = 2048,
	parameter int DEPTH = 2097152,
	parameter int AW    = 21
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	output logic            busy,
	input  wire             kind,
	input  fwk_pkg::row_t   row,
	input  fwk_pkg::col_t   col,
	input  fwk_pkg::val_t   value,
	output logic            done,
	output fwk_pkg::val_t   sum,
	input  fwk_pkg::val_t   m,
	output logic            rd_en,
	output logic [AW-1:0]   rd_addr,
	input  fwk_pkg::val_t   rd_data,
	output logic            wr_en,
	output logic [AW-1:0]   wr_addr,
	output fwk_pkg::val_t   wr_data,
	output logic            mod_start,
	output fwk_pkg::wide_t  mod_x,
	input  wire             mod_done,
	input  fwk_pkg::val_t   mod_rem
);
	import fwk_pkg::*;

	localparam int RA  = $clog2(ROWS) + 2;
	localparam int CA  = $clog2(COLS) + 2;
	localparam int RIW = (RA > ROW_W) ? RA : ROW_W;
	localparam int CIW = (CA > COL_W) ? CA : COL_W;
	localparam logic [RIW-1:0] ROW_MAX = RIW'(ROWS);
	localparam logic [CIW-1:0] COL_MAX = CIW'(COLS);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_VRED = 3'd2;
	localparam logic [2:0] S_ROW  = 3'd3;
	localparam logic [2:0] S_RD   = 3'd4;
	localparam logic [2:0] S_ACC  = 3'd5;
	localparam logic [2:0] S_MOD  = 3'd6;

	logic [2:0]     state_q;
	logic [AW-1:0]  clr_q;
	logic           upd_q;
	logic [RIW-1:0] r_q;
	logic [CIW-1:0] c_q;
	logic [CIW-1:0] c0_q;
	val_t           addend_q;
	logic [AW-1:0]  row_base_q;
	logic [AW-1:0]  addr_q;
	logic           done_q;
	val_t           sum_q;

	logic [RIW-1:0] row_x, r0, lb_r, r_nx;
	logic [CIW-1:0] col_x, c0, lb_c, c_nx;
	logic           r_end, c_end;
	logic           accept, is_upd, no_area, bad_upd;
	wide_t          acc16;
	logic           fast;
	val_t           fast_res, res;
	logic           node_fin;

	always_comb begin
		row_x   = RIW'(row);
		col_x   = CIW'(col);
		r0      = (row_x > ROW_MAX) ? ROW_MAX : row_x;
		c0      = (col_x > COL_MAX) ? COL_MAX : col_x;
		accept  = (state_q == S_IDLE) && start;
		is_upd  = (kind == KIND_UPDATE);
		no_area = (row_x == '0) || (col_x == '0);
		bad_upd = no_area || (row_x > ROW_MAX) || (col_x > COL_MAX);

		lb_r  = r_q & (~r_q + 1'b1);
		lb_c  = c_q & (~c_q + 1'b1);
		r_nx  = upd_q ? (r_q + lb_r) : (r_q - lb_r);
		c_nx  = upd_q ? (c_q + lb_c) : (c_q - lb_c);
		r_end = upd_q ? (r_nx > ROW_MAX) : (r_nx == '0);
		c_end = upd_q ? (c_nx > COL_MAX) : (c_nx == '0);

		acc16    = {1'b0, rd_data} + {1'b0, addend_q};
		fast     = acc16 < {m, 1'b0};
		fast_res = (acc16 < {1'b0, m}) ? val_t'(acc16) : val_t'(acc16 - {1'b0, m});
		node_fin = ((state_q == S_ACC) && fast) || ((state_q == S_MOD) && mod_done);
		res      = (state_q == S_MOD) ? mod_rem : fast_res;

		rd_en   = (state_q == S_RD);
		rd_addr = row_base_q + AW'(c_q - 1'b1);
		wr_en   = (state_q == S_CLR) || (node_fin && upd_q);
		wr_addr = (state_q == S_CLR) ? clr_q : addr_q;
		wr_data = (state_q == S_CLR) ? val_t'(0) : res;

		mod_start = (accept && is_upd && !bad_upd) || ((state_q == S_ACC) && !fast);
		mod_x     = (state_q == S_IDLE) ? {1'b0, value} : acc16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q) inside
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						if (no_area && !is_upd)
							done_q <= 1'b1;
						else if (is_upd && !bad_upd)
							state_q <= S_VRED;
						else if (!is_upd)
							state_q <= S_ROW;
					end
				end
				S_VRED: begin
					if (mod_done)
						state_q <= S_ROW;
				end
				S_ROW: state_q <= S_RD;
				S_RD:  state_q <= S_ACC;
				S_ACC, S_MOD: begin
					if (state_q == S_ACC && !fast)
						state_q <= S_MOD;
					else if (node_fin) begin
						if (!c_end)
							state_q <= S_RD;
						else if (!r_end)
							state_q <= S_ROW;
						else begin
							state_q <= S_IDLE;
							done_q  <= !upd_q;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			upd_q    <= is_upd;
			r_q      <= is_upd ? row_x : r0;
			c0_q     <= is_upd ? col_x : c0;
			addend_q <= '0;
			sum_q    <= '0;
		end
		if (state_q == S_VRED && mod_done)
			addend_q <= mod_rem;
		if (state_q == S_ROW) begin
			row_base_q <= AW'((r_q - 1'b1) * COLS);
			c_q        <= c0_q;
		end
		if (state_q == S_RD)
			addr_q <= rd_addr;
		if (node_fin) begin
			if (!upd_q) begin
				addend_q <= res;
				sum_q    <= res;
			end
			if (!c_end)
				c_q <= c_nx;
			else if (!r_end)
				r_q <= r_nx;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign sum  = sum_q;

endmodule

`default_nettype wire

/* sv/fenwick_2d_modular_prefix_sum.sv */
// Channel | Ports                          | Handshake
// --------+--------------------------------+------------------------------------
// input   | kind, row, col, value          | taken on start high while busy low
// result  | sum                            | one cycle, marked by done
// config  | cfg_wdata                      | written on cfg_we, no wait
//
// After reset all ROWS*COLS node entries are swept to zero, one entry a cycle;
// busy stays high for that sweep.
// A query takes a row step per row node and a read and an add-reduce step per node;
// an update first reduces its word by shift-subtract and writes each node back. A
// node sum of twice the modulus or more adds shift-subtract reduction to that node.
// The receiver cannot stall, and done pulses in the cycle after the last node of a
// query (or after taking a query with a zero row or column).
`default_nettype none

module fenwick_2d_modular_prefix_sum #(
	parameter int ROWS = 1024,
	parameter int COLS = 2048
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	output logic           busy,
	input  wire            kind,
	input  fwk_pkg::row_t  row,
	input  fwk_pkg::col_t  col,
	input  fwk_pkg::val_t  value,
	output logic           done,
	output fwk_pkg::val_t  sum,
	input  wire            cfg_we,
	input  fwk_pkg::val_t  cfg_wdata
);
	import fwk_pkg::*;

	localparam int DEPTH = ROWS * COLS;
	localparam int AW    = $clog2(DEPTH);

	val_t          modulus_q;
	val_t          m_act;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	val_t          rd_data, wr_data;
	logic          mod_start, mod_done;
	wide_t         mod_x;
	val_t          mod_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			modulus_q <= MOD_RESET;
		else if (cfg_we)
			modulus_q <= cfg_wdata;
	end

	assign m_act = (modulus_q < MOD_MIN) ? MOD_MIN : modulus_q;

	fwk_ctrl #(
		.ROWS (ROWS),
		.COLS (COLS),
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.kind     (kind),
		.row      (row),
		.col      (col),
		.value    (value),
		.done     (done),
		.sum      (sum),
		.m        (m_act),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.mod_start(mod_start),
		.mod_x    (mod_x),
		.mod_done (mod_done),
		.mod_rem  (mod_rem)
	);

	fwk_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	fwk_mod u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.x     (mod_x),
		.m     (m_act),
		.done  (mod_done),
		.rem   (mod_rem)
	);

endmodule

`default_nettype wire
